// File: rtl/lru_tlb_hit_counter_defines.svh
// Assertion helpers shared by the RTL. Every check is clocked on clk and is
// switched off while the synchronous reset is held.
`ifndef LRU_TLB_HIT_COUNTER_DEFINES_SVH
`define LRU_TLB_HIT_COUNTER_DEFINES_SVH

// Same-cycle implication.
`define LTHC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LTHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lrutlb_pkg.sv
package lrutlb_pkg;

  localparam int ENTRIES_DEF      = 16;
  localparam int ADDRESS_BITS_DEF = 32;

  localparam int MIN_PAGE_SHIFT = 10;
  localparam int MAX_PAGE_SHIFT = 20;

  // Configuration register file.
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  typedef logic [CFG_W-1:0]     cfg_word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_ENTRIES_IN_USE = 1'd0;
  localparam cfg_idx_t CFG_PAGE_SHIFT     = 1'd1;

  localparam cfg_word_t ENTRIES_IN_USE_RST = 5'd16;
  localparam cfg_word_t PAGE_SHIFT_RST     = 5'd12;

  localparam int HIT_W = 32;
  typedef logic [HIT_W-1:0] hit_cnt_t;

endpackage

// File: rtl/lrutlb_cam.sv
module lrutlb_cam
  import lrutlb_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int TAG_W   = ADDRESS_BITS_DEF - MIN_PAGE_SHIFT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             upd_en,
  input  logic [TAG_W-1:0] page,
  input  cfg_word_t        entries_in_use,
  output logic             hit
);

  localparam int RW = $clog2(ENTRIES);
  localparam int FW = $clog2(ENTRIES + 1);
  localparam int CW = (FW > CFG_W) ? FW : CFG_W;

  logic [TAG_W-1:0] tag_r   [ENTRIES];
  logic [RW-1:0]    rank_r  [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [FW-1:0]    fill_r;

  logic [ENTRIES-1:0] hit_vec, hit_first, free_first, evict_vec, slot;
  logic [RW-1:0]      hit_rank, fill_m1;
  logic [RW:0]        old_rank;
  logic [CW-1:0]      cap, cfg_ext, fill_ext;
  logic               room;

  // Effective capacity: zero acts as one, anything above the array size is capped.
  assign cfg_ext  = CW'(entries_in_use);
  assign fill_ext = CW'(fill_r);
  always_comb begin
    if (cfg_ext == '0) begin
      cap = CW'(1);
    end else if (cfg_ext > CW'(ENTRIES)) begin
      cap = CW'(ENTRIES);
    end else begin
      cap = cfg_ext;
    end
  end
  assign room    = fill_ext < cap;
  assign fill_m1 = RW'(fill_r - FW'(1));

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]   = valid_r[i] && (tag_r[i] == page);
      // Valid ranks are a permutation of 0..fill-1, so the oldest holds fill-1.
      evict_vec[i] = valid_r[i] && (rank_r[i] == fill_m1);
    end
  end

  assign hit_first  = hit_vec & (~hit_vec + ENTRIES'(1));
  assign free_first = ~valid_r & (valid_r + ENTRIES'(1));
  assign hit        = |hit_vec;

  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_first[i]) begin
        hit_rank = hit_rank | rank_r[i];
      end
    end
  end

  // A fresh entry ages every valid entry, hence an old rank of ENTRIES.
  always_comb begin
    if (hit) begin
      slot     = hit_first;
      old_rank = {1'b0, hit_rank};
    end else if (room) begin
      slot     = free_first;
      old_rank = (RW + 1)'(ENTRIES);
    end else begin
      slot     = evict_vec;
      old_rank = {1'b0, fill_m1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (upd_en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot[i]) begin
          rank_r[i] <= '0;
        end else if (valid_r[i] && ({1'b0, rank_r[i]} < old_rank)) begin
          rank_r[i] <= rank_r[i] + RW'(1);
        end
      end
      if (!hit) begin
        valid_r <= valid_r | slot;
        if (room) begin
          fill_r <= fill_r + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en && !hit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot[i]) begin
          tag_r[i] <= page;
        end
      end
    end
  end

endmodule

// File: rtl/lru_tlb_hit_counter.sv
// Fully associative TLB with least-recently-used replacement and a
// saturating hit counter.
// Input channel: in_valid / in_stall carry one byte address per request.
// Result channel: out_valid / out_stall carry the hit flag and the running
// hit total, including this request, for every request, in order.
// Configuration: cfg_we writes cfg_wdata into the register chosen by
// cfg_index (entries in use, page shift); write only while the block is idle.
// Timing: a request is held in the input register while the tag array is
// searched and updated, then its result is registered and shown on out_valid.
// One request per cycle is sustained while out_stall is low; the search and
// rank update are combinational, which sets that figure.
// Reset empties the TLB, clears the hit total and restores 16 entries in use
// and a 4 KB page. When out_stall holds a result, the input register fills
// and then in_stall is raised; nothing is dropped.
`include "lru_tlb_hit_counter_defines.svh"

module lru_tlb_hit_counter
  import lrutlb_pkg::*;
#(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [ADDRESS_BITS-1:0] in_address,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_hit,
  output hit_cnt_t                out_hit_total,
  input  logic                    cfg_we,
  input  cfg_idx_t                cfg_index,
  input  cfg_word_t               cfg_wdata
);

  localparam int TAG_W = ADDRESS_BITS - MIN_PAGE_SHIFT;

  cfg_word_t entries_in_use_r, page_shift_r, shift_eff;

  logic                    s1_vld_r;
  logic [ADDRESS_BITS-1:0] s1_addr_r;
  logic                    out_vld_r, out_hit_r;
  hit_cnt_t                out_hit_total_r;
  hit_cnt_t                hit_count_r, hit_count_nxt;

  logic                    advance, in_take, lk_hit;
  logic [ADDRESS_BITS-1:0] shifted;
  logic [TAG_W-1:0]        page;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r <= ENTRIES_IN_USE_RST;
      page_shift_r     <= PAGE_SHIFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENTRIES_IN_USE: entries_in_use_r <= cfg_wdata;
        CFG_PAGE_SHIFT:     page_shift_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (page_shift_r < CFG_W'(MIN_PAGE_SHIFT)) begin
      shift_eff = CFG_W'(MIN_PAGE_SHIFT);
    end else if (page_shift_r > CFG_W'(MAX_PAGE_SHIFT)) begin
      shift_eff = CFG_W'(MAX_PAGE_SHIFT);
    end else begin
      shift_eff = page_shift_r;
    end
  end

  assign shifted = s1_addr_r >> shift_eff;
  assign page    = shifted[TAG_W-1:0];

  // The held request moves on whenever the result register is free or drains.
  assign advance  = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  lrutlb_cam #(
    .ENTRIES (ENTRIES),
    .TAG_W   (TAG_W)
  ) u_cam (
    .clk            (clk),
    .rst_n          (rst_n),
    .upd_en         (advance),
    .page           (page),
    .entries_in_use (entries_in_use_r),
    .hit            (lk_hit)
  );

  always_comb begin
    hit_count_nxt = hit_count_r;
    if (advance && lk_hit && (hit_count_r != '1)) begin
      hit_count_nxt = hit_count_r + HIT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      hit_count_r <= '0;
    end else begin
      hit_count_r <= hit_count_nxt;
      if (in_take) begin
        s1_vld_r <= 1'b1;
      end else if (advance) begin
        s1_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_addr_r <= in_address;
    end
    if (advance) begin
      out_hit_r       <= lk_hit;
      out_hit_total_r <= hit_count_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_hit       = out_hit_r;
  assign out_hit_total = out_hit_total_r;

  `LTHC_ASSERT_NEXT(a_hit_counts, advance && lk_hit && (hit_count_r != '1),
    hit_count_r == $past(hit_count_r) + HIT_W'(1), "hit not counted")
  `LTHC_ASSERT_NEXT(a_miss_holds, advance && !lk_hit,
    $stable(hit_count_r), "hit total moved on a miss")
  `LTHC_ASSERT_NEXT(a_result_total, advance,
    out_vld_r && (out_hit_total_r == hit_count_r), "result total out of step")
  `LTHC_ASSERT_NOW(a_stall_cause, in_stall,
    s1_vld_r && out_vld_r && out_stall, "input stalled without back-pressure")

endmodule
